/* rtl/csc_measurement_parser_unit_defines.svh */
// Assertion macros for the measurement parser.
`ifndef CSC_MEASUREMENT_PARSER_UNIT_DEFINES_SVH
`define CSC_MEASUREMENT_PARSER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define CSC_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("csc parser assertion failed");
`define CSC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("csc parser assertion failed");
`else
`define CSC_ASSERT_IMPLIES(label, ante, cons)
`define CSC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

/* rtl/csc_mp_pkg.sv */
// Types and constants of the measurement parser.
`default_nettype none

package csc_mp_pkg;

  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 104;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam int unsigned WHEEL_FLAG_BIT = 0;
  localparam int unsigned CRANK_FLAG_BIT = 1;

  localparam logic [15:0] OWN_CONNECTION_RESET = 16'hFFFF;
  localparam logic [15:0] MEAS_HANDLE_RESET    = 16'h0000;

  localparam logic [3:0] POSITION_MAX = 4'd15;

  typedef enum logic [0:0] {
    CFG_OWN_CONNECTION = 1'b0,
    CFG_MEAS_HANDLE    = 1'b1
  } cfg_index_t;

  // Declared from the highest bit down, so record_link sits in the lowest bits.
  typedef struct packed {
    logic        short_packet;
    logic [15:0] crank_event_time;
    logic [15:0] crank_revolutions;
    logic [15:0] wheel_event_time;
    logic [31:0] wheel_revolutions;
    logic        crank_data_present;
    logic        wheel_data_present;
    logic [15:0] record_link;
  } record_t;

  localparam int unsigned RECORD_W = $bits(record_t);

endpackage

`default_nettype wire

/* rtl/csc_measurement_parser_unit.sv */
// Cycling speed and cadence measurement parser, top level.
//
// Notification bytes arrive on the slave stream, one byte per beat, with the
// connection and attribute handles beside each byte. tuser marks the flags
// byte and tlast the final byte. When the handles of the flags byte match the
// configured ones, the wheel and crank fields are assembled little-endian and
// one record leaves on the master stream after the final byte.
// A record is registered when the closing beat is taken, and a beat can be
// accepted every cycle unless the slave side stalls. The record register is
// backed by one skid register: the slave side stalls only when both hold
// records that the receiver has not yet taken. Reset empties both registers,
// closes any open notification and loads own_connection with 65535 and
// measurement_value_handle with 0. The user is to write configuration through
// cfg_we, cfg_addr and cfg_data while idle; the block does not enforce it.
`default_nettype none

`include "csc_measurement_parser_unit_defines.svh"

module csc_measurement_parser_unit
  import csc_mp_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [0:0]             cfg_addr,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // data_byte [7:0], link_handle [23:8], attribute_handle [39:24]
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  wire logic                   s_axis_tlast,
  // first_byte [0]
  input  wire logic                   s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // record_link [15:0], wheel_data_present [16], crank_data_present [17],
  // wheel_revolutions [49:18], wheel_event_time [65:50],
  // crank_revolutions [81:66], crank_event_time [97:82], short_packet [98]
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata
);

  logic [15:0] own_connection;
  logic [15:0] meas_handle;

  logic [3:0]  byte_position;
  logic [3:0]  byte_position_next;
  logic [1:0]  flag_bits;
  logic [1:0]  flag_bits_next;
  logic        packet_matches;
  logic        packet_matches_next;
  logic [31:0] wheel_count_acc;
  logic [31:0] wheel_count_acc_next;
  logic [15:0] wheel_time_acc;
  logic [15:0] wheel_time_acc_next;
  logic [15:0] crank_count_acc;
  logic [15:0] crank_count_acc_next;
  logic [15:0] crank_time_acc;
  logic [15:0] crank_time_acc_next;
  logic [15:0] latched_link;
  logic [15:0] latched_link_next;

  record_t     out_rec;
  record_t     skid_rec;
  logic        skid_valid;
  record_t     new_rec;
  logic        rec_fire;

  logic        in_fire;
  logic        out_free;
  logic [7:0]  data_byte;
  logic [15:0] link_handle;
  logic [15:0] attribute_handle;
  logic        wheel;
  logic        crank;
  logic [3:0]  crank_base;
  logic [3:0]  crank_rel;
  logic [1:0]  wheel_lane;
  logic [3:0]  wheel_time_rel;
  logic [3:0]  position_upd;
  logic [3:0]  expected;

  assign data_byte        = s_axis_tdata[7:0];
  assign link_handle      = s_axis_tdata[23:8];
  assign attribute_handle = s_axis_tdata[39:24];

  assign s_axis_tready = !skid_valid;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  assign wheel          = flag_bits[WHEEL_FLAG_BIT];
  assign crank          = flag_bits[CRANK_FLAG_BIT];
  assign crank_base     = wheel ? 4'd7 : 4'd1;
  assign crank_rel      = byte_position - crank_base;
  assign wheel_lane     = 2'(byte_position - 4'd1);
  assign wheel_time_rel = byte_position - 4'd5;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_connection <= OWN_CONNECTION_RESET;
      meas_handle    <= MEAS_HANDLE_RESET;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_addr))
        CFG_OWN_CONNECTION: own_connection <= cfg_data;
        CFG_MEAS_HANDLE:    meas_handle    <= cfg_data;
        default:            ;
      endcase
    end
  end

  always_comb begin
    flag_bits_next       = flag_bits;
    packet_matches_next  = packet_matches;
    wheel_count_acc_next = wheel_count_acc;
    wheel_time_acc_next  = wheel_time_acc;
    crank_count_acc_next = crank_count_acc;
    crank_time_acc_next  = crank_time_acc;
    latched_link_next    = latched_link;
    position_upd         = byte_position;
    byte_position_next   = byte_position;
    rec_fire             = 1'b0;

    if (in_fire) begin
      if (s_axis_tuser) begin
        packet_matches_next  = (link_handle == own_connection) &&
                               (attribute_handle == meas_handle);
        latched_link_next    = link_handle;
        flag_bits_next       = data_byte[1:0];
        position_upd         = 4'd1;
        wheel_count_acc_next = '0;
        wheel_time_acc_next  = '0;
        crank_count_acc_next = '0;
        crank_time_acc_next  = '0;
      end else if (packet_matches) begin
        if (wheel && (byte_position inside {[4'd1:4'd4]})) begin
          wheel_count_acc_next[{wheel_lane, 3'b000} +: 8] = data_byte;
        end else if (wheel && (byte_position inside {[4'd5:4'd6]})) begin
          wheel_time_acc_next[{wheel_time_rel[0], 3'b000} +: 8] = data_byte;
        end else if (crank && (byte_position >= crank_base) &&
                     (crank_rel inside {[4'd0:4'd1]})) begin
          crank_count_acc_next[{crank_rel[0], 3'b000} +: 8] = data_byte;
        end else if (crank && (byte_position >= crank_base) &&
                     (crank_rel inside {[4'd2:4'd3]})) begin
          crank_time_acc_next[{crank_rel[0], 3'b000} +: 8] = data_byte;
        end
        if (byte_position < POSITION_MAX) begin
          position_upd = byte_position + 4'd1;
        end
      end

      byte_position_next = position_upd;
      if (s_axis_tlast) begin
        rec_fire            = packet_matches_next;
        packet_matches_next = 1'b0;
        byte_position_next  = '0;
      end
    end
  end

  always_comb begin
    expected = 4'd1 + (flag_bits_next[WHEEL_FLAG_BIT] ? 4'd6 : 4'd0) +
               (flag_bits_next[CRANK_FLAG_BIT] ? 4'd4 : 4'd0);
    new_rec.record_link        = latched_link_next;
    new_rec.wheel_data_present = flag_bits_next[WHEEL_FLAG_BIT];
    new_rec.crank_data_present = flag_bits_next[CRANK_FLAG_BIT];
    new_rec.wheel_revolutions  = wheel_count_acc_next;
    new_rec.wheel_event_time   = wheel_time_acc_next;
    new_rec.crank_revolutions  = crank_count_acc_next;
    new_rec.crank_event_time   = crank_time_acc_next;
    new_rec.short_packet       = position_upd < expected;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= '0;
      flag_bits      <= '0;
      packet_matches <= 1'b0;
    end else begin
      byte_position  <= byte_position_next;
      flag_bits      <= flag_bits_next;
      packet_matches <= packet_matches_next;
    end
  end

  always_ff @(posedge clk) begin
    wheel_count_acc <= wheel_count_acc_next;
    wheel_time_acc  <= wheel_time_acc_next;
    crank_count_acc <= crank_count_acc_next;
    crank_time_acc  <= crank_time_acc_next;
    latched_link    <= latched_link_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      skid_valid    <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        m_axis_tvalid <= 1'b1;
        skid_valid    <= rec_fire;
      end else begin
        m_axis_tvalid <= rec_fire;
      end
    end else if (rec_fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_rec <= skid_rec;
        if (rec_fire) begin
          skid_rec <= new_rec;
        end
      end else if (rec_fire) begin
        out_rec <= new_rec;
      end
    end else if (rec_fire) begin
      skid_rec <= new_rec;
    end
  end

  assign m_axis_tdata = {(OUT_TDATA_W - RECORD_W)'(0), out_rec};

  `CSC_ASSERT_IMPLIES(a_skid_behind_output, skid_valid, m_axis_tvalid)
  `CSC_ASSERT_IMPLIES(a_open_has_position, packet_matches, byte_position != 4'd0)
  `CSC_ASSERT_NEXT(a_last_closes, in_fire && s_axis_tlast, !packet_matches)
  `CSC_ASSERT_NEXT(a_stalled_record_kept, rec_fire && !out_free, skid_valid)

endmodule

`default_nettype wire

/* tb/tb.sv */
// Testbench of the measurement parser: predicted records checked against the master stream.
`default_nettype none

module tb
  import csc_mp_pkg::*;
();

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned SETTLE_CYCLES = 4;

  typedef struct packed {
    logic [15:0] attr;
    logic [15:0] link;
    logic [7:0]  data;
    logic        first;
    logic        last;
  } beat_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [0:0]             cfg_addr;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   s_axis_tlast;
  logic                   s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  csc_measurement_parser_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  beat_t   beats_pending[$];
  record_t records_due[$];

  // Copy of the configuration and of the parser state.
  logic [15:0] served_link = OWN_CONNECTION_RESET;
  logic [15:0] meas_handle = MEAS_HANDLE_RESET;
  logic [3:0]  pos_count   = '0;
  logic [1:0]  flags_seen  = '0;
  logic        open_match  = 1'b0;
  logic [31:0] wheel_count = '0;
  logic [15:0] wheel_time  = '0;
  logic [15:0] crank_count = '0;
  logic [15:0] crank_time  = '0;
  logic [15:0] held_link   = '0;

  int unsigned cycles     = 0;
  int unsigned errors     = 0;
  int unsigned send_gap   = 0;
  int unsigned recv_stall = 0;
  bit          gaps_on    = 1'b1;
  bit          in_taken   = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic parse_notification_byte(input beat_t bt);
    int      p;
    int      base;
    logic    wh;
    logic    cr;
    int      need;
    record_t rec;
    if (bt.first) begin
      open_match  = (bt.link == served_link) && (bt.attr == meas_handle);
      held_link   = bt.link;
      flags_seen  = bt.data[1:0];
      pos_count   = 4'd1;
      wheel_count = '0;
      wheel_time  = '0;
      crank_count = '0;
      crank_time  = '0;
    end else if (open_match) begin
      p    = pos_count;
      wh   = flags_seen[WHEEL_FLAG_BIT];
      cr   = flags_seen[CRANK_FLAG_BIT];
      base = wh ? 7 : 1;
      if (wh && p >= 1 && p <= 4) begin
        wheel_count[8*(p-1) +: 8] |= bt.data;
      end else if (wh && p >= 5 && p <= 6) begin
        wheel_time[8*(p-5) +: 8] |= bt.data;
      end else if (cr && p >= base && p <= base + 1) begin
        crank_count[8*(p-base) +: 8] |= bt.data;
      end else if (cr && p >= base + 2 && p <= base + 3) begin
        crank_time[8*(p-base-2) +: 8] |= bt.data;
      end
      if (pos_count < POSITION_MAX) pos_count = pos_count + 4'd1;
    end
    if (bt.last) begin
      if (open_match) begin
        need = 1 + 6 * flags_seen[WHEEL_FLAG_BIT] + 4 * flags_seen[CRANK_FLAG_BIT];
        rec.record_link        = held_link;
        rec.wheel_data_present = flags_seen[WHEEL_FLAG_BIT];
        rec.crank_data_present = flags_seen[CRANK_FLAG_BIT];
        rec.wheel_revolutions  = wheel_count;
        rec.wheel_event_time   = wheel_time;
        rec.crank_revolutions  = crank_count;
        rec.crank_event_time   = crank_time;
        rec.short_packet       = (int'(pos_count) < need);
        records_due.push_back(rec);
      end
      open_match = 1'b0;
      pos_count  = '0;
    end
  endtask

  task automatic report_field(input string name, input logic [31:0] exp, input logic [31:0] act);
    if (exp !== act) begin
      $error("%s: expected %0h, actual %0h", name, exp, act);
      errors++;
    end
  endtask

  // Monitor: configuration copy, record checks and prediction of accepted beats.
  always @(posedge clk) begin
    record_t got;
    record_t exp;
    if (!rst) begin
      if (cfg_we) begin
        case (cfg_index_t'(cfg_addr))
          CFG_OWN_CONNECTION: served_link = cfg_data;
          CFG_MEAS_HANDLE:    meas_handle = cfg_data;
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = record_t'(m_axis_tdata[RECORD_W-1:0]);
        if (records_due.size() == 0) begin
          $error("record beat with no record expected: %0h", got);
          errors++;
        end else begin
          exp = records_due.pop_front();
          report_field("record_link", exp.record_link, got.record_link);
          report_field("wheel_data_present", exp.wheel_data_present, got.wheel_data_present);
          report_field("crank_data_present", exp.crank_data_present, got.crank_data_present);
          report_field("wheel_revolutions", exp.wheel_revolutions, got.wheel_revolutions);
          report_field("wheel_event_time", exp.wheel_event_time, got.wheel_event_time);
          report_field("crank_revolutions", exp.crank_revolutions, got.crank_revolutions);
          report_field("crank_event_time", exp.crank_event_time, got.crank_event_time);
          report_field("short_packet", exp.short_packet, got.short_packet);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        parse_notification_byte({s_axis_tdata[39:24], s_axis_tdata[23:8], s_axis_tdata[7:0],
                                 s_axis_tuser, s_axis_tlast});
        in_taken = 1'b1;
      end
    end
  end

  // Driver of the slave stream.
  always @(negedge clk) begin
    beat_t bt;
    if (!rst && (!s_axis_tvalid || in_taken)) begin
      in_taken = 1'b0;
      if (send_gap > 0) begin
        s_axis_tvalid <= 1'b0;
        send_gap--;
      end else if (beats_pending.size() > 0) begin
        bt = beats_pending.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {bt.attr, bt.link, bt.data};
        s_axis_tuser  <= bt.first;
        s_axis_tlast  <= bt.last;
        if (gaps_on && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 15);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver of the master stream.
  always @(negedge clk) begin
    if (recv_stall > 0) begin
      m_axis_tready <= 1'b0;
      recv_stall--;
    end else begin
      m_axis_tready <= 1'b1;
      if (gaps_on && $urandom_range(0, 7) == 0) recv_stall = $urandom_range(1, 15);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic push_beat(input logic [7:0] d, input logic f, input logic l,
                           input logic [15:0] lk, input logic [15:0] at);
    beat_t bt;
    bt.data  = d;
    bt.first = f;
    bt.last  = l;
    bt.link  = lk;
    bt.attr  = at;
    beats_pending.push_back(bt);
  endtask

  // A notification of n beats; fill below zero gives random payload bytes.
  task automatic push_packet(input logic [15:0] lk, input logic [15:0] at,
                             input logic [7:0] flags, input int n, input int fill,
                             input bit closed, input bit wander);
    logic [7:0] d;
    for (int i = 0; i < n; i++) begin
      d = (fill < 0) ? 8'($urandom) : 8'(fill);
      if (i == 0) begin
        push_beat(flags, 1'b1, closed && (n == 1), lk, at);
      end else if (wander) begin
        push_beat(d, 1'b0, closed && (i == n - 1), 16'($urandom), 16'($urandom));
      end else begin
        push_beat(d, 1'b0, closed && (i == n - 1), lk, at);
      end
    end
  endtask

  task automatic queue_random_notification(output int counted);
    int          kind;
    logic [7:0]  flags;
    int          need;
    int          n;
    logic [15:0] lk;
    logic [15:0] at;
    kind    = $urandom_range(0, 19);
    flags   = 8'($urandom);
    need    = 1 + 6 * flags[WHEEL_FLAG_BIT] + 4 * flags[CRANK_FLAG_BIT];
    lk      = served_link;
    at      = meas_handle;
    counted = 0;
    if (kind <= 1) begin
      repeat ($urandom_range(1, 3)) push_beat(8'($urandom), 1'b0, 1'($urandom),
                                              16'($urandom), 16'($urandom));
    end else if (kind == 2) begin
      if ($urandom_range(0, 1)) lk ^= 16'(1) << $urandom_range(0, 15);
      else at ^= 16'(1) << $urandom_range(0, 15);
      push_packet(lk, at, flags, $urandom_range(1, need + 2), -1, 1'b1, 1'b0);
    end else begin
      if (kind == 3) n = $urandom_range(1, need + 2);
      else if (kind == 4) n = (need > 1) ? $urandom_range(1, need - 1) : 1;
      else if (kind == 5) n = need + (($urandom_range(0, 3) == 0) ? $urandom_range(9, 14)
                                                                   : $urandom_range(1, 8));
      else n = need;
      push_packet(lk, at, flags, n, -1, kind != 3, $urandom_range(0, 3) == 0);
      counted = n;
    end
  endtask

  task automatic settle();
    while (beats_pending.size() != 0 || s_axis_tvalid || records_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  initial begin
    int counted;
    int total;
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_addr      = CFG_OWN_CONNECTION;
    cfg_data      = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    s_axis_tuser  = 1'b0;
    m_axis_tready = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset handles, then the extreme handles the other way round.
    push_packet(16'hFFFF, 16'h0000, 8'h03, 11, 8'hFF, 1'b1, 1'b0);
    settle();
    write_reg(CFG_OWN_CONNECTION, 16'h0000);
    write_reg(CFG_MEAS_HANDLE, 16'hFFFF);
    push_packet(16'h0000, 16'hFFFF, 8'hFF, 1, 0, 1'b1, 1'b0);
    push_packet(16'h0000, 16'hFFFF, 8'h00, 1, 0, 1'b1, 1'b0);
    push_beat(8'hA5, 1'b0, 1'b1, 16'h0000, 16'hFFFF);
    push_packet(16'h0001, 16'hFFFF, 8'h03, 2, 8'hFF, 1'b1, 1'b0);
    push_packet(16'h0000, 16'hFFFE, 8'h03, 2, 8'hFF, 1'b1, 1'b0);
    push_packet(16'h0000, 16'hFFFF, 8'h01, 3, 8'h5A, 1'b0, 1'b0);
    push_packet(16'h0000, 16'hFFFF, 8'hFD, 7, 8'h00, 1'b1, 1'b1);
    push_packet(16'h0000, 16'hFFFF, 8'h02, 3, -1, 1'b1, 1'b0);
    settle();

    for (int phase = 0; phase < 4; phase++) begin
      write_reg(CFG_OWN_CONNECTION, 16'($urandom));
      write_reg(CFG_MEAS_HANDLE, 16'($urandom));
      if (phase == 3) gaps_on = 1'b0;
      total = 0;
      while (total < 140) begin
        queue_random_notification(counted);
        total += counted;
      end
      settle();
    end

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
